// ===== rtl/afqa_pkg.sv =====
// ----------------------------------------------------------------------------
// afqa_pkg: shared definitions for the audio frame queue accounting block
// field widths, operation codes and parameter defaults
// ----------------------------------------------------------------------------
`default_nettype none

package afqa_pkg;

    // request and result field widths
    localparam int OP_W     = 2;
    localparam int AMOUNT_W = 18;
    localparam int WAIT_W   = 17;
    localparam int BUFS_W   = 5;
    localparam int STAT_W   = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_SUBMIT_FRAMES  = 2'd0;
    localparam logic [OP_W-1:0] OP_SUBMIT_SAMPLES = 2'd1;
    localparam logic [OP_W-1:0] OP_CONSUME        = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR          = 2'd3;

    // parameter defaults
    localparam int MAX_BUFFERS_DEF = 16;
    localparam int MAX_FRAMES_DEF  = 65536;
    localparam int CHANNELS_DEF    = 2;

endpackage

`default_nettype wire

// ===== rtl/audio_frame_queue_accounting.sv =====
// ----------------------------------------------------------------------------
// audio_frame_queue_accounting
// queue of buffer lengths in frames with front offset, underrun and play stats
// ----------------------------------------------------------------------------
//  channel   | handshake                   | payload
//  request   | i_in_valid / o_in_ready     | i_operation, i_amount
//  result    | o_out_valid / i_out_ready   | o_accepted, o_frames_taken,
//            |                             | o_frames_waiting, o_buffers_waiting,
//            |                             | o_frames_played, o_frames_short,
//            |                             | o_buffers_submitted
//
//  submit by frames: accept, push, post
//  submit by samples: accept, divide, check, push, post; the divide by the
//  channel count is a reciprocal multiply, then a multiply back checks for
//  an even split; an uneven count posts after the check, a zero count after accept
//  consume: accept and post, plus memory read, take, update per buffer touched
//  clear: accept and post; one request at a time, the next one is taken while a
//  result still waits in the output register
//  reset is synchronous active low; the length memory is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module audio_frame_queue_accounting #(
    parameter int MAX_BUFFERS = afqa_pkg::MAX_BUFFERS_DEF,
    parameter int MAX_FRAMES  = afqa_pkg::MAX_FRAMES_DEF,
    parameter int CHANNELS    = afqa_pkg::CHANNELS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [afqa_pkg::OP_W-1:0]     i_operation,
    input  wire logic [afqa_pkg::AMOUNT_W-1:0] i_amount,

    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_accepted,
    output logic [afqa_pkg::AMOUNT_W-1:0]      o_frames_taken,
    output logic [afqa_pkg::WAIT_W-1:0]        o_frames_waiting,
    output logic [afqa_pkg::BUFS_W-1:0]        o_buffers_waiting,
    output logic [afqa_pkg::STAT_W-1:0]        o_frames_played,
    output logic [afqa_pkg::STAT_W-1:0]        o_frames_short,
    output logic [afqa_pkg::STAT_W-1:0]        o_buffers_submitted
);

    localparam int AW    = afqa_pkg::AMOUNT_W;
    localparam int SW_ST = afqa_pkg::STAT_W;
    localparam int WW    = afqa_pkg::WAIT_W;
    localparam int BW    = afqa_pkg::BUFS_W;
    // queue index, buffer count and frame total widths
    localparam int IW    = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
    localparam int CNT_W = $clog2(MAX_BUFFERS + 1);
    localparam int TW    = $clog2(MAX_FRAMES + 1);
    // stored length and front offset never exceed the request width
    localparam int LW    = (TW < AW) ? TW : AW;
    // width for total plus a new buffer without overflow
    localparam int SW    = ((TW > AW) ? TW : AW) + 1;
    // reciprocal of the channel count, exact over the whole request range
    // for channel counts up to eight
    localparam int              DIV_SH = AW + 3;
    localparam logic [DIV_SH:0] DIV_M  = (DIV_SH+1)'(
        ((64'd1 << DIV_SH) + 64'(CHANNELS) - 64'd1) / 64'(CHANNELS));

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_PUSH = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_TAKE = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_CHK  = 3'd7;

    // control and queue state
    logic [2:0]                      r_state,  n_state;
    logic [IW-1:0]                   r_head,   n_head;
    logic [IW-1:0]                   r_tail,   n_tail;
    logic [CNT_W-1:0]                r_count,  n_count;
    logic [LW-1:0]                   r_off,    n_off;
    logic [TW-1:0]                   r_total,  n_total;
    logic [SW_ST-1:0]                r_played, n_played;
    logic [SW_ST-1:0]                r_short,  n_short;
    logic [SW_ST-1:0]                r_submit, n_submit;
    logic                            r_out_valid, n_out_valid;

    // working registers of the current request
    logic [AW-1:0]                   r_amt,  n_amt;
    logic [AW-1:0]                   r_quo,  n_quo;
    logic [AW-1:0]                   r_want, n_want;
    logic [AW-1:0]                   r_got,  n_got;
    logic [AW-1:0]                   r_take, n_take;
    logic                            r_acc,  n_acc;

    // result register
    logic                            r_out_acc;
    logic [AW-1:0]                   r_out_taken;
    logic [afqa_pkg::WAIT_W-1:0]     r_out_wait;
    logic [afqa_pkg::BUFS_W-1:0]     r_out_bufs;
    logic [SW_ST-1:0]                r_out_played;
    logic [SW_ST-1:0]                r_out_short;
    logic [SW_ST-1:0]                r_out_submit;
    logic                            w_out_load;

    // buffer length memory, one write port and one registered read port
    logic [LW-1:0]                   r_mem [MAX_BUFFERS];
    logic [LW-1:0]                   r_rd_len;
    logic                            w_mem_we;

    // shared datapath terms
    logic [AW+DIV_SH-1:0]            w_div_prod;
    logic [AW+2:0]                   w_div_back;
    logic                            w_div_exact;
    logic [SW-1:0]                   w_push_sum;
    logic                            w_push_ok;
    logic [AW-1:0]                   w_avail;
    logic [AW-1:0]                   w_off_sum;
    logic                            w_pop;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        // quotient by reciprocal multiply, then multiply back for the split check
        w_div_prod  = (AW+DIV_SH)'(r_amt) * (AW+DIV_SH)'(DIV_M);
        w_div_back  = (AW+3)'(r_quo) * (AW+3)'(CHANNELS);
        w_div_exact = (w_div_back == (AW+3)'(r_amt));

        // push check against zero amount, buffer and frame limits
        w_push_sum = SW'(r_total) + SW'(r_amt);
        w_push_ok  = (r_amt != '0) && (r_count < CNT_W'(MAX_BUFFERS))
                     && (w_push_sum <= SW'(MAX_FRAMES));

        // frames left in the front buffer
        w_avail = (r_rd_len > r_off) ? (AW'(r_rd_len) - AW'(r_off)) : '0;

        // front offset after the take, pop once the buffer is used up
        w_off_sum = AW'(r_off) + r_take;
        w_pop     = (w_off_sum >= AW'(r_rd_len));
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_off       = r_off;
        n_total     = r_total;
        n_played    = r_played;
        n_short     = r_short;
        n_submit    = r_submit;
        n_out_valid = r_out_valid;
        n_amt       = r_amt;
        n_quo       = r_quo;
        n_want      = r_want;
        n_got       = r_got;
        n_take      = r_take;
        n_acc       = r_acc;
        w_mem_we    = 1'b0;
        w_out_load  = 1'b0;

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_acc  = 1'b0;
                    n_got  = '0;
                    n_want = '0;
                    n_amt  = i_amount;
                    case (i_operation)
                        afqa_pkg::OP_SUBMIT_FRAMES: begin
                            n_state = S_PUSH;
                        end
                        afqa_pkg::OP_SUBMIT_SAMPLES: begin
                            // zero sample count is rejected right away
                            n_state = (i_amount == '0) ? S_FIN : S_DIV;
                        end
                        afqa_pkg::OP_CONSUME: begin
                            // empty queue: the whole request becomes underrun
                            n_want  = i_amount;
                            n_state = ((i_amount != '0) && (r_count != '0)) ? S_READ : S_FIN;
                        end
                        default: begin
                            // clear: queue and statistics back to reset values, memory keeps stale lengths
                            n_head   = '0;
                            n_tail   = '0;
                            n_count  = '0;
                            n_off    = '0;
                            n_total  = '0;
                            n_played = '0;
                            n_short  = '0;
                            n_submit = '0;
                            n_state  = S_FIN;
                        end
                    endcase
                end
            end

            S_DIV: begin
                n_quo   = w_div_prod[DIV_SH +: AW];
                n_state = S_CHK;
            end

            S_CHK: begin
                // sample count must split evenly across channels
                if (w_div_exact) begin
                    n_amt   = r_quo;
                    n_state = S_PUSH;
                end else begin
                    n_state = S_FIN;
                end
            end

            S_PUSH: begin
                if (w_push_ok) begin
                    w_mem_we = 1'b1;
                    n_tail   = (r_tail == IW'(MAX_BUFFERS - 1)) ? '0 : r_tail + 1'b1;
                    n_count  = r_count + 1'b1;
                    n_total  = w_push_sum[TW-1:0];
                    n_submit = r_submit + 1'b1;
                    n_acc    = 1'b1;
                end
                n_state = S_FIN;
            end

            S_READ: begin
                // memory read of the front length lands at this edge
                n_state = S_TAKE;
            end

            S_TAKE: begin
                n_take  = (r_want < w_avail) ? r_want : w_avail;
                n_state = S_UPD;
            end

            S_UPD: begin
                n_off    = w_pop ? '0 : w_off_sum[LW-1:0];
                n_want   = r_want - r_take;
                n_got    = r_got + r_take;
                n_total  = (SW'(r_total) >= SW'(r_take))
                           ? TW'(SW'(r_total) - SW'(r_take)) : '0;
                n_played = r_played + SW_ST'(r_take);
                if (w_pop) begin
                    n_head  = (r_head == IW'(MAX_BUFFERS - 1)) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                end
                n_state = ((n_want != '0) && (n_count != '0)) ? S_READ : S_FIN;
            end

            S_FIN: begin
                // wait for a free result slot, then post and book the underrun
                if (!r_out_valid || i_out_ready) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_short     = r_short + SW_ST'(r_want);
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_off       <= '0;
            r_total     <= '0;
            r_played    <= '0;
            r_short     <= '0;
            r_submit    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_off       <= n_off;
            r_total     <= n_total;
            r_played    <= n_played;
            r_short     <= n_short;
            r_submit    <= n_submit;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers and result payload
    always_ff @(posedge i_clk) begin
        r_amt  <= n_amt;
        r_quo  <= n_quo;
        r_want <= n_want;
        r_got  <= n_got;
        r_take <= n_take;
        r_acc  <= n_acc;
        if (w_out_load) begin
            r_out_acc    <= r_acc;
            r_out_taken  <= r_got;
            r_out_wait   <= WW'(r_total);
            r_out_bufs   <= BW'(r_count);
            r_out_played <= r_played;
            r_out_short  <= n_short;
            r_out_submit <= r_submit;
        end
    end

    // length memory
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_tail] <= r_amt[LW-1:0];
        end
        r_rd_len <= r_mem[r_head];
    end

    assign o_out_valid         = r_out_valid;
    assign o_accepted          = r_out_acc;
    assign o_frames_taken      = r_out_taken;
    assign o_frames_waiting    = r_out_wait;
    assign o_buffers_waiting   = r_out_bufs;
    assign o_frames_played     = r_out_played;
    assign o_frames_short      = r_out_short;
    assign o_buffers_submitted = r_out_submit;

`ifndef SYNTH
    // buffer count stays within the queue depth
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BUFFERS))
        else $error("buffer count above queue depth");

    // an empty queue holds no frames and no front offset
    a_empty_consistent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> ((r_total == '0) && (r_off == '0)))
        else $error("empty queue with frames or offset left");

    // a queued submit never reports consumed frames
    a_accept_no_take : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |-> (o_frames_taken == '0))
        else $error("accepted submit reports frames taken");

    // a result post leaves a valid result and returns to idle
    a_post_from_fin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load) |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("result post did not return to idle");
`endif

endmodule

`default_nettype wire
